[sv/des_pkg.sv]
package des_pkg;

    localparam int unsigned BLOCK_W = 64;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned RKEY_W  = 48;
    localparam int unsigned ROUNDS  = 16;

    typedef enum logic [0:0] {
        REG_CIPHER_KEY   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } t_reg_idx;

    typedef logic [RKEY_W-1:0] t_rkey;

    localparam logic [7:0] TAB_IP [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

    localparam logic [7:0] TAB_FP [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

    localparam logic [7:0] TAB_E [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};

    localparam logic [7:0] TAB_P [32] = '{
        16,7,20,21, 29,12,28,17, 1,15,23,26, 5,18,31,10,
        2,8,24,14, 32,27,3,9, 19,13,30,6, 22,11,4,25};

    localparam logic [7:0] TAB_PC1 [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

    localparam logic [7:0] TAB_PC2 [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
        16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
        44,49,39,56,34,53, 46,42,50,36,29,32};

    localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] TAB_S [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] f_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic logic [63:0] f_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TAB_FP[i])];
        return r;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TAB_PC1[i])];
        return r;
    endfunction

    function automatic t_rkey f_pc2(input logic [55:0] v);
        t_rkey r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TAB_PC2[i])];
        return r;
    endfunction

    function automatic logic [27:0] f_rot(input logic [27:0] x, input logic [1:0] s);
        return (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    endfunction

    function automatic logic [31:0] f_feistel(input logic [31:0] r, input t_rkey k);
        logic [47:0] e;
        logic [31:0] s;
        logic [5:0]  six;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TAB_E[i])];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = TAB_S[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TAB_P[i])];
        return p;
    endfunction

endpackage

[sv/des_block_cipher.sv]
// DES (FIPS 46-3) block cipher, one 64-bit block per beat. The sixteen Feistel rounds
// are unrolled into sixteen register stages plus an input (IP) stage, so a new block is
// taken every cycle unless an output stall has filled the pipeline. A stall on the output
// freezes the whole pipeline, filling bubbles first. Round keys are derived from the
// key register by a constant network; key and mode may only change while the pipeline
// is empty. Register 0 is the 64-bit key (parity ignored), register 1 bit 0 selects
// decryption.
module des_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result_block
);
    import des_pkg::*;

    localparam int unsigned NSTG = ROUNDS + 1;

    logic [KEY_W-1:0] r_key;
    logic             r_dec;
    t_rkey            w_rk [ROUNDS];
    logic [27:0]      w_c [ROUNDS+1];
    logic [27:0]      w_d [ROUNDS+1];

    logic [NSTG-1:0]  r_vld;
    logic [31:0]      r_l [NSTG];
    logic [31:0]      r_r [NSTG];
    logic [NSTG-1:0]  w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_dec <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CIPHER_KEY:   r_key <= i_cfg_data;
                REG_DECRYPT_MODE: r_dec <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        {w_c[0], w_d[0]} = f_pc1(r_key);
        for (int i = 0; i < ROUNDS; i++) begin
            w_c[i+1] = f_rot(w_c[i], TAB_ROT[i]);
            w_d[i+1] = f_rot(w_d[i], TAB_ROT[i]);
            w_rk[i]  = f_pc2({w_c[i+1], w_d[i+1]});
        end
    end

    // stage k advances when downstream is free or it holds a bubble
    always_comb begin
        w_adv[NSTG-1] = m_axis_tready || !r_vld[NSTG-1];
        for (int k = NSTG-2; k >= 0; k--) w_adv[k] = w_adv[k+1] || !r_vld[k];
    end

    assign s_axis_tready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NSTG; k++)
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) {r_l[0], r_r[0]} <= f_ip(s_axis_tdata);
        for (int k = 1; k < NSTG; k++) begin
            if (w_adv[k]) begin
                r_l[k] <= r_r[k-1];
                r_r[k] <= r_l[k-1] ^ f_feistel(r_r[k-1],
                          r_dec ? w_rk[ROUNDS-k] : w_rk[k-1]);
            end
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = f_fp({r_r[NSTG-1], r_l[NSTG-1]});

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> s_axis_tready)
        else $error("input blocked with empty entry stage");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat lost");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

endmodule

[sim/tb_des_block_cipher.sv]
module tb_des_block_cipher;
    import des_pkg::*;

    localparam int LATENCY   = 17;
    localparam int WD_LIMIT  = 4000;
    localparam int N_RANDOM  = 1400;

    typedef struct {
        logic [63:0] blk;
        logic        has_exp;
        logic [63:0] exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    logic [63:0] cur_key;
    logic        cur_decrypt;
    logic [63:0] expected_blocks[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          idle_cycles;
    bit          hold_req;
    bit          stim_done;

    des_block_cipher u_top (.*);

    always #4 i_clk = ~i_clk;

    // Table positions are 1-based bit numbers counted from the MSB.
    function automatic logic bit_select(input logic [63:0] v, input int in_w,
                                        input int pos);
        return v[in_w - pos];
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] ex;
        logic [31:0] sb;
        logic [31:0] pr;
        logic [5:0]  six;
        int          row;
        int          col;
        for (int i = 0; i < 48; i++) ex[47-i] = r[32-TAB_E[i]];
        ex ^= k;
        for (int i = 0; i < 8; i++) begin
            six = ex[47-6*i -: 6];
            row = int'({six[5], six[0]});
            col = int'(six[4:1]);
            sb[31-4*i -: 4] = TAB_S[i][row*16+col];
        end
        for (int i = 0; i < 32; i++) pr[31-i] = sb[32-TAB_P[i]];
        return pr;
    endfunction

    function automatic logic [63:0] des_compute(input logic [63:0] key, input logic dec,
                                                input logic [63:0] blk);
        logic [47:0] rk[16];
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] b;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] nr;
        logic [63:0] pre;
        logic [63:0] res;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            for (int s = 0; s < TAB_ROT[i]; s++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            for (int j = 0; j < 48; j++) rk[i][47-j] = bit_select({8'd0, c, d}, 56, TAB_PC2[j]);
        end
        for (int i = 0; i < 64; i++) b[63-i] = blk[64-TAB_IP[i]];
        l = b[63:32];
        r = b[31:0];
        for (int i = 0; i < 16; i++) begin
            nr = l ^ round_fn(r, rk[dec ? 15 - i : i]);
            l = r;
            r = nr;
        end
        pre = {r, l};
        for (int i = 0; i < 64; i++) res[63-i] = pre[64-TAB_FP[i]];
        return res;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_CIPHER_KEY) cur_key = val;
        else cur_decrypt = val[0];
    endtask

    task automatic drain();
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_block(input logic [63:0] blk, input bit has_exp,
                              input logic [63:0] exp);
        logic [63:0] pred;
        int gap;
        pred = des_compute(cur_key, cur_decrypt, blk);
        if (has_exp && pred !== exp) begin
            $display("%0t predictor disagrees: exp %h got %h", $time, exp, pred);
            errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(has_exp ? exp : pred);
        n_sent++;
        gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 15) == 0) ?
              $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // receiver
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_req = 0;
            end
            if ($urandom_range(0, 4) == 0) begin
                stall = ($urandom_range(0, 10) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // checker
    always @(posedge i_clk) begin
        logic [63:0] exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t unexpected beat: got %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp = expected_blocks.pop_front();
                n_checked++;
                if (m_axis_tdata !== exp) begin
                    $display("%0t result_block mismatch: exp %h got %h",
                             $time, exp, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || (stim_done && expected_blocks.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row dir_rows[$];
        logic [63:0] keys[6];
        dir_rows = '{
            '{64'h0000_0000_0000_0000, 1'b1, 64'h8CA6_4DE9_C1B1_23A7},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
            '{64'h0000_0000_0000_0001, 1'b0, 64'h0},
            '{64'h8000_0000_0000_0000, 1'b0, 64'h0},
            '{64'h5555_5555_5555_5555, 1'b0, 64'h0},
            '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
            '{64'h0123_4567_89AB_CDEF, 1'b0, 64'h0}
        };
        // zero key, weak keys, semi-weak, textbook key, all ones
        keys = '{64'h0, 64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
                 64'h01FE_01FE_01FE_01FE, 64'h1334_5779_9BBC_DFF1,
                 64'hFFFF_FFFF_FFFF_FFFF};
        errors = 0; n_sent = 0; n_checked = 0; idle_cycles = 0;
        hold_req = 0; stim_done = 0;
        cur_key = '0; cur_decrypt = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_block(dir_rows[i].blk, dir_rows[i].has_exp,
                                         dir_rows[i].exp);
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(REG_CIPHER_KEY, 64'h1334_5779_9BBC_DFF1);
        send_block(64'h0123_4567_89AB_CDEF, 1'b1, 64'h85E8_1354_0F0A_B405);
        s_axis_tvalid <= 1'b0;
        drain();
        // high data bits on the mode register must be dropped
        write_reg(REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h85E8_1354_0F0A_B405, 1'b1, 64'h0123_4567_89AB_CDEF);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 14; ph++) begin
            drain();
            write_reg(REG_CIPHER_KEY, (ph < 6) ? keys[ph] : rnd64());
            write_reg(REG_DECRYPT_MODE, {$urandom, 31'd0, 1'($urandom_range(0, 1))});
            if (ph == 3) hold_req = 1;
            for (int i = 0; i < N_RANDOM / 14; i++)
                send_block(($urandom_range(0, 9) == 0) ?
                           (($urandom_range(0, 1) != 0) ? 64'h0 : '1) : rnd64(), 0, 0);
            s_axis_tvalid <= 1'b0;
        end
        stim_done = 1;
        drain();
        $display("covered %0d blocks over 17 key/mode settings, %0d results checked",
                 n_sent, n_checked);
        if (errors == 0 && expected_blocks.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[files.f]
sv/des_pkg.sv
sv/des_block_cipher.sv
sim/tb_des_block_cipher.sv
